/* rtl/whtst_pkg.sv */
package whtst_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_ENTRIES_DEF = 16;
	localparam int COORD_BITS_DEF  = 8;

	// Fixed field widths of the interface
	localparam int ENTRY_IDX_W = 4;
	localparam int WIN_IDX_W   = 4;
	localparam int ACTIVE_W    = 5;

	// Request kinds
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// Queue head as seen by the execution side
	typedef struct packed {
		logic vld;
		logic is_query;
	} whtst_head_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} whtst_state_t;

endpackage

/* rtl/window_hit_tester.sv */
// Rectangle hit tester. Keeps a table of MAX_ENTRIES rectangles (origin, width,
// height) and answers click queries with the lowest-index entry among the first
// active_windows that contains the click; the left column of each rectangle does
// not count. A write item (req_type 0) stores one entry and returns nothing; a
// write to an index at or above MAX_ENTRIES is dropped. A query item (req_type 1)
// returns exactly one transfer on the rsp channel: hit and window_index, with
// window_index 0 on a miss. Items are taken into a two-deep queue, so the request
// side keeps moving while the table sequencer works or while a result waits, until
// both slots are full. The sequencer reads one table entry per cycle from a RAM
// with separate write and read ports and a registered read. A query reads entries
// in order up to the first hit or the search count; with a search count of zero it
// answers a miss without a read. A query starts only once the previous result has
// been taken. Entries must be written before a query searches them; active_windows
// saturates at MAX_ENTRIES. The user must write it only while the block is idle;
// the block does not enforce this. No clearing pass follows reset.
module window_hit_tester #(
	parameter int MAX_ENTRIES = whtst_pkg::MAX_ENTRIES_DEF,
	parameter int COORD_BITS  = whtst_pkg::COORD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [whtst_pkg::ACTIVE_W-1:0]   cfg_wr_data,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  logic                             req_type,
	input  logic [whtst_pkg::ENTRY_IDX_W-1:0] entry_index,
	input  logic [COORD_BITS-1:0]            origin_x,
	input  logic [COORD_BITS-1:0]            origin_y,
	input  logic [COORD_BITS-1:0]            rect_width,
	input  logic [COORD_BITS-1:0]            rect_height,
	input  logic [COORD_BITS-1:0]            click_x,
	input  logic [COORD_BITS-1:0]            click_y,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output logic                             hit,
	output logic [whtst_pkg::WIN_IDX_W-1:0]  window_index
);

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int PW    = IDX_W + 4 * COORD_BITS;

	logic [whtst_pkg::ACTIVE_W-1:0] active_q;
	whtst_pkg::whtst_head_t         head;
	logic [PW-1:0]                  head_payload;
	logic                           pop;

	// Hold the search count; update on every configuration write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (cfg_wr_en) begin
			active_q <= cfg_wr_data;
		end
	end

	// Front: accept and classify request transfers, drop out-of-range writes,
	// and buffer the rest in order.
	whtst_front #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_type    (req_type),
		.entry_index (entry_index),
		.origin_x    (origin_x),
		.origin_y    (origin_y),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.click_x     (click_x),
		.click_y     (click_y),
		.head        (head),
		.head_payload(head_payload),
		.pop         (pop)
	);

	// Back: apply writes to the table, walk the table for queries, and hold
	// each result in the output register until it is transferred.
	whtst_back #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.head_payload  (head_payload),
		.pop           (pop),
		.active_windows(active_q),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.hit           (hit),
		.window_index  (window_index)
	);

endmodule

/* rtl/whtst_ram.sv */
module whtst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/whtst_front.sv */
module whtst_front #(
	parameter int MAX_ENTRIES = whtst_pkg::MAX_ENTRIES_DEF,
	parameter int COORD_BITS  = whtst_pkg::COORD_BITS_DEF,
	localparam int IDX_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
	localparam int PW         = IDX_W + 4 * COORD_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  logic                             req_type,
	input  logic [whtst_pkg::ENTRY_IDX_W-1:0] entry_index,
	input  logic [COORD_BITS-1:0]            origin_x,
	input  logic [COORD_BITS-1:0]            origin_y,
	input  logic [COORD_BITS-1:0]            rect_width,
	input  logic [COORD_BITS-1:0]            rect_height,
	input  logic [COORD_BITS-1:0]            click_x,
	input  logic [COORD_BITS-1:0]            click_y,
	output whtst_pkg::whtst_head_t           head,
	output logic [PW-1:0]                    head_payload,
	input  logic                             pop
);

	logic [PW-1:0] slot_q [2];
	logic          kind_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;

	logic          accept;
	logic          in_range;
	logic          push;
	logic [PW-1:0] payload;

	assign req_stall = (cnt_q == 2'd2);
	assign accept    = req_valid && !req_stall;
	assign in_range  = (32'(entry_index) < 32'(MAX_ENTRIES));
	// drop writes aimed past the table
	assign push      = accept && ((req_type == whtst_pkg::REQ_QUERY) || in_range);

	always_comb begin
		if (req_type == whtst_pkg::REQ_QUERY) begin
			payload = {IDX_W'(0), click_x, click_y, {(2 * COORD_BITS){1'b0}}};
		end else begin
			payload = {IDX_W'(entry_index), origin_x, origin_y, rect_width, rect_height};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= payload;
			kind_q[wr_ptr_q] <= req_type;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assign head.vld      = (cnt_q != 2'd0);
	assign head.is_query = kind_q[rd_ptr_q];
	assign head_payload  = slot_q[rd_ptr_q];

`ifndef SYNTHESIS
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (cnt_q != 2'd0))
		else $error("queue popped while empty");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q <= 2'd2) && (((cnt_q == 2'd0) || (cnt_q == 2'd2)) == (wr_ptr_q == rd_ptr_q)))
		else $error("queue count and pointers disagree");
`endif

endmodule

/* rtl/whtst_back.sv */
module whtst_back #(
	parameter int MAX_ENTRIES = whtst_pkg::MAX_ENTRIES_DEF,
	parameter int COORD_BITS  = whtst_pkg::COORD_BITS_DEF,
	localparam int IDX_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
	localparam int CNT_W      = $clog2(MAX_ENTRIES + 1),
	localparam int PW         = IDX_W + 4 * COORD_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  whtst_pkg::whtst_head_t          head,
	input  logic [PW-1:0]                   head_payload,
	output logic                            pop,
	input  logic [whtst_pkg::ACTIVE_W-1:0]  active_windows,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output logic                            hit,
	output logic [whtst_pkg::WIN_IDX_W-1:0] window_index
);

	localparam int CW = COORD_BITS;

	whtst_pkg::whtst_state_t state_q, state_d;

	logic [CW-1:0]    cx_q, cy_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic             chk_vld_s1;
	logic [IDX_W-1:0] chk_idx_s1;
	logic             rsp_vld_q;
	logic             hit_q;
	logic [whtst_pkg::WIN_IDX_W-1:0] win_q;

	logic             out_free;
	logic [CNT_W-1:0] n_sat;
	logic             start;
	logic             issue;
	logic             finish;
	logic             ram_we;
	logic [4*CW-1:0]  ram_rdata;

	logic [CW-1:0]    ox, oy, rw, rh;
	logic [CW:0]      right, bottom, left_in;
	logic             contains;
	logic             last;

	assign out_free = !rsp_vld_q || !rsp_stall;
	assign n_sat    = (32'(active_windows) > 32'(MAX_ENTRIES)) ?
	                  CNT_W'(MAX_ENTRIES) : CNT_W'(active_windows);

	whtst_ram #(
		.WIDTH(4 * CW),
		.DEPTH(MAX_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(head_payload[PW-1 -: IDX_W]),
		.wdata(head_payload[4*CW-1:0]),
		.re   (issue),
		.raddr(rd_idx_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	// hit test on the entry read in the previous cycle
	assign ox       = ram_rdata[4*CW-1 -: CW];
	assign oy       = ram_rdata[3*CW-1 -: CW];
	assign rw       = ram_rdata[2*CW-1 -: CW];
	assign rh       = ram_rdata[CW-1:0];
	assign right    = {1'b0, ox} + {1'b0, rw};
	assign bottom   = {1'b0, oy} + {1'b0, rh};
	assign left_in  = {1'b0, ox} + (CW+1)'(1);
	assign contains = ({1'b0, cy_q} >= {1'b0, oy}) && ({1'b0, cy_q} < bottom) &&
	                  ({1'b0, cx_q} >= left_in) && ({1'b0, cx_q} < right);
	assign last     = ((CNT_W'(chk_idx_s1) + CNT_W'(1)) == n_q);
	assign finish   = (state_q == whtst_pkg::ST_SCAN) && chk_vld_s1 && (contains || last);

	// control outputs
	always_comb begin
		pop    = 1'b0;
		ram_we = 1'b0;
		start  = 1'b0;
		issue  = 1'b0;
		unique case (state_q)
			whtst_pkg::ST_IDLE: begin
				if (head.vld) begin
					if (head.is_query == whtst_pkg::REQ_WRITE) begin
						ram_we = 1'b1;
						pop    = 1'b1;
					end else if (out_free) begin
						pop   = 1'b1;
						start = 1'b1;
					end
				end
			end
			whtst_pkg::ST_SCAN: begin
				issue = (rd_idx_q < n_q) && !finish;
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			whtst_pkg::ST_IDLE: begin
				if (start && (n_sat != '0)) begin
					state_d = whtst_pkg::ST_SCAN;
				end
			end
			whtst_pkg::ST_SCAN: begin
				if (finish) begin
					state_d = whtst_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = whtst_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= whtst_pkg::ST_IDLE;
			chk_vld_s1 <= 1'b0;
			rsp_vld_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			chk_vld_s1 <= issue;
			if ((start && (n_sat == '0)) || finish) begin
				rsp_vld_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cx_q     <= head_payload[4*CW-1 -: CW];
			cy_q     <= head_payload[3*CW-1 -: CW];
			n_q      <= n_sat;
			rd_idx_q <= '0;
		end else if (issue) begin
			rd_idx_q <= rd_idx_q + CNT_W'(1);
		end
		if (issue) begin
			chk_idx_s1 <= rd_idx_q[IDX_W-1:0];
		end
		if (start && (n_sat == '0)) begin
			hit_q <= 1'b0;
			win_q <= '0;
		end else if (finish) begin
			hit_q <= contains;
			win_q <= contains ? whtst_pkg::WIN_IDX_W'(chk_idx_s1) : '0;
		end
	end

	assign rsp_valid    = rsp_vld_q;
	assign hit          = hit_q;
	assign window_index = win_q;

`ifndef SYNTHESIS
	a_check_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		chk_vld_s1 |-> (state_q == whtst_pkg::ST_SCAN))
		else $error("entry check outside a scan");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == whtst_pkg::ST_SCAN) |-> ((rd_idx_q <= n_q) && (n_q != '0)))
		else $error("scan index past search count");

	a_out_free_on_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(start && (n_sat != '0)) |=> !rsp_vld_q)
		else $error("scan started with a result still pending");
`endif

endmodule
